>>> hdl/opd_pkg.sv
package opd_pkg;

    localparam int GAIN_W  = 16;
    localparam int DIST_W  = 15;
    localparam int DUTY_W  = 15;
    localparam int SPEED_W = 18;
    localparam int INTEG_W = 32;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int MIX_W   = 37;
    localparam int WHEEL_W = MIX_W - 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_P_RST          = 16'd1638;
    localparam logic [GAIN_W-1:0] GAIN_I_RST          = 16'd328;
    localparam logic [GAIN_W-1:0] GAIN_D_RST          = 16'd655;
    localparam logic [DIST_W-1:0] TARGET_DISTANCE_RST = 15'd560;
    localparam logic [DUTY_W-1:0] DUTY_CAP_RST        = 15'd6554;
    localparam logic [DIST_W-1:0] RANGE_LIMIT_RST     = 15'd19248;

    localparam logic [7:0] HOST_CENTRE = 8'd127;
    localparam logic signed [MUL_A_W-1:0] HALF_ROOT3_Q16 = 17'sd56756;
    localparam logic signed [WHEEL_W-1:0] SPEED_LIMIT    = 21'sd32440;
    localparam logic signed [SPEED_W-1:0] DUTY_FLOOR     = -18'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P          = 3'd0,
        REG_GAIN_I          = 3'd1,
        REG_GAIN_D          = 3'd2,
        REG_TARGET_DISTANCE = 3'd3,
        REG_DUTY_CAP        = 3'd4,
        REG_RANGE_LIMIT     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_SRC_P   = 2'd0,
        MUL_SRC_I   = 2'd1,
        MUL_SRC_D   = 2'd2,
        MUL_SRC_MIX = 2'd3
    } mul_src_t;

    typedef struct packed {
        logic              host_valid;
        logic [7:0]        host_byte;
        logic [DIST_W-1:0] distance;
    } loop_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] wheel_one_fwd;
        logic [DUTY_W-1:0] wheel_one_rev;
        logic [DUTY_W-1:0] wheel_two_fwd;
        logic [DUTY_W-1:0] wheel_two_rev;
        logic [DUTY_W-1:0] wheel_three_fwd;
        logic [DUTY_W-1:0] wheel_three_rev;
        logic              mode_now;
    } drive_item_t;

    typedef struct packed {
        logic     load_in;
        logic     decide;
        logic     mul_en;
        mul_src_t mul_src;
        logic     acc_load;
        logic     acc_add;
        logic     duty_load;
        logic     out_load;
    } opd_cmd_t;

    typedef struct packed {
        logic pid_go;
        logic out_free;
    } opd_status_t;

    // (byte-127)*32768/127 toward zero: 32768 = 127*258 + 2
    function automatic logic signed [SPEED_W-1:0] steer_speed(input logic [7:0] b);
        logic [7:0]         n;
        logic [SPEED_W-1:0] mag;
        logic [1:0]         rnd;
        n = (b >= HOST_CENTRE) ? (b - HOST_CENTRE) : (HOST_CENTRE - b);
        if (n >= 8'd127)
            rnd = 2'd2;
        else if (n >= 8'd64)
            rnd = 2'd1;
        else
            rnd = 2'd0;
        mag = (SPEED_W'(n) << 8) + (SPEED_W'(n) << 1) + SPEED_W'(rnd);
        return (b < HOST_CENTRE) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [WHEEL_W-1:0] clamp_wheel(
        input logic signed [WHEEL_W-1:0] w
    );
        if (w <= -SPEED_LIMIT)
            return -SPEED_LIMIT;
        if (w >= SPEED_LIMIT)
            return SPEED_LIMIT;
        return w;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_fwd(input logic signed [WHEEL_W-1:0] w);
        return w[WHEEL_W-1] ? '0 : w[DUTY_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] duty_rev(input logic signed [WHEEL_W-1:0] w);
        logic signed [WHEEL_W-1:0] m;
        m = -w;
        return w[WHEEL_W-1] ? m[DUTY_W-1:0] : '0;
    endfunction

endpackage

>>> hdl/opd_ctrl.sv
module opd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 loop_valid,
    output logic                 loop_stall,
    input  opd_pkg::opd_status_t status,
    output opd_pkg::opd_cmd_t    cmd
);
    import opd_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_DECIDE  = 9'b000000010,
        ST_MUL_P   = 9'b000000100,
        ST_MUL_I   = 9'b000001000,
        ST_MUL_D   = 9'b000010000,
        ST_ACC     = 9'b000100000,
        ST_DUTY    = 9'b001000000,
        ST_MIX_MUL = 9'b010000000,
        ST_MIX     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign loop_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_src = MUL_SRC_P;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (loop_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.pid_go ? ST_MUL_P : ST_MIX_MUL;
            end
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MUL_SRC_P;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = MUL_SRC_I;
                cmd.acc_load = 1'b1;
                state_next   = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MUL_SRC_D;
                cmd.acc_add = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DUTY;
            end
            ST_DUTY:
            begin
                cmd.duty_load = 1'b1;
                state_next    = ST_MIX_MUL;
            end
            ST_MIX_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MUL_SRC_MIX;
                state_next  = ST_MIX;
            end
            ST_MIX:
            begin
                // hold until the result register can take the beat
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/opd_datapath.sv
module opd_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [opd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [opd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  opd_pkg::loop_item_t                  loop_item,
    output logic                                 drive_valid,
    input  logic                                 drive_stall,
    output opd_pkg::drive_item_t                 drive_item,
    input  opd_pkg::opd_cmd_t                    cmd,
    output opd_pkg::opd_status_t                 status
);
    import opd_pkg::*;

    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DIST_W-1:0] target_reg, range_limit_reg;
    logic [DUTY_W-1:0] duty_cap_reg;

    logic                       mode_reg;
    logic signed [SPEED_W-1:0]  speed_fwd_reg, speed_lat_reg;
    logic signed [INTEG_W-1:0]  integral_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;

    loop_item_t                 item_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg;

    drive_item_t                out_reg;
    logic                       out_valid_reg, out_valid_next;

    logic signed [ERR_W-1:0]    err;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [INTEG_W-1:0]  integ_sat;
    logic signed [DIFF_W-1:0]   diff;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;

    logic signed [ACC_W-6:0]    duty;
    logic signed [SPEED_W-1:0]  duty_sat;

    logic signed [MIX_W-1:0]    fwd_term, lat_term, mix_two, mix_three;
    logic signed [WHEEL_W-1:0]  w1, w2, w3;

    assign status.pid_go   = mode_reg && (item_reg.distance < range_limit_reg);
    assign status.out_free = !out_valid_reg || !drive_stall;

    assign err       = $signed({2'b00, item_reg.distance}) - $signed({2'b00, target_reg});
    assign integ_sum = (INTEG_W+1)'(integral_reg) + (INTEG_W+1)'(err);
    assign diff      = DIFF_W'(err) - DIFF_W'(prev_err_reg);

    always_comb
    begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
            integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            integ_sat = integ_sum[INTEG_W-1:0];
    end

    always_comb
    begin
        case (cmd.mul_src)
            MUL_SRC_P:
            begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_SRC_I:
            begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = integral_reg;
            end
            MUL_SRC_D:
            begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = MUL_B_W'(diff_reg);
            end
            default:
            begin
                mul_a = HALF_ROOT3_Q16;
                mul_b = MUL_B_W'(speed_lat_reg);
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign duty = (ACC_W-5)'(acc_reg >>> 5);

    always_comb
    begin
        if (duty > $signed({{(ACC_W-5-DUTY_W){1'b0}}, duty_cap_reg}))
            duty_sat = $signed({{(SPEED_W-DUTY_W){1'b0}}, duty_cap_reg});
        else if (duty < (ACC_W-5)'(DUTY_FLOOR))
            duty_sat = DUTY_FLOOR;
        else
            duty_sat = duty[SPEED_W-1:0];
    end

    assign fwd_term  = MIX_W'(speed_fwd_reg) <<< 15;
    assign lat_term  = prod_reg[MIX_W-1:0];
    assign mix_two   = lat_term - fwd_term;
    assign mix_three = -lat_term - fwd_term;
    assign w1 = clamp_wheel(WHEEL_W'(speed_fwd_reg));
    assign w2 = clamp_wheel(WHEEL_W'(mix_two >>> 16));
    assign w3 = clamp_wheel(WHEEL_W'(mix_three >>> 16));

    always_comb
    begin
        out_valid_next = out_valid_reg && drive_stall;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= GAIN_P_RST;
            gain_i_reg      <= GAIN_I_RST;
            gain_d_reg      <= GAIN_D_RST;
            target_reg      <= TARGET_DISTANCE_RST;
            duty_cap_reg    <= DUTY_CAP_RST;
            range_limit_reg <= RANGE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:          gain_p_reg      <= cfg_data;
                REG_GAIN_I:          gain_i_reg      <= cfg_data;
                REG_GAIN_D:          gain_d_reg      <= cfg_data;
                REG_TARGET_DISTANCE: target_reg      <= cfg_data[DIST_W-1:0];
                REG_DUTY_CAP:        duty_cap_reg    <= cfg_data[DUTY_W-1:0];
                REG_RANGE_LIMIT:     range_limit_reg <= cfg_data[DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            speed_fwd_reg <= '0;
            speed_lat_reg <= '0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.decide)
            begin
                if (!mode_reg)
                begin
                    if (item_reg.host_valid)
                    begin
                        speed_fwd_reg <= steer_speed(item_reg.host_byte);
                        speed_lat_reg <= '0;
                        if (item_reg.host_byte == HOST_CENTRE)
                            mode_reg <= 1'b1;
                    end
                end
                else if (status.pid_go)
                begin
                    integral_reg <= integ_sat;
                    prev_err_reg <= err;
                    if (item_reg.distance == target_reg)
                        mode_reg <= 1'b0;
                end
            end
            if (cmd.duty_load)
            begin
                speed_lat_reg <= duty_sat;
                speed_fwd_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            item_reg <= loop_item;
        if (cmd.decide)
        begin
            err_reg  <= err;
            diff_reg <= diff;
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.acc_load)
            acc_reg <= ACC_W'(prod_reg);
        else if (cmd.acc_add)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (cmd.out_load)
        begin
            out_reg.wheel_one_fwd   <= duty_fwd(w1);
            out_reg.wheel_one_rev   <= duty_rev(w1);
            out_reg.wheel_two_fwd   <= duty_fwd(w2);
            out_reg.wheel_two_rev   <= duty_rev(w2);
            out_reg.wheel_three_fwd <= duty_fwd(w3);
            out_reg.wheel_three_rev <= duty_rev(w3);
            out_reg.mode_now        <= mode_reg;
        end
    end

    assign drive_valid = out_valid_reg;
    assign drive_item  = out_reg;

endmodule

>>> hdl/omniwheel_pid_approach_drive_top.sv
// Three-wheel omni drive with distance PID approach.
// loop channel (loop_valid / loop_stall / loop_item): one beat per control
//   loop with the optional host byte and the range sample.
// drive channel (drive_valid / drive_stall / drive_item): one beat per loop
//   beat with the six PWM duties and the mode after the loop.
// cfg port: cfg_we, cfg_index, cfg_data write one register per cycle;
//   write only while no loop beat is in flight.
// Steps: decide, mix multiply, output load in steer mode or out of range;
//   with the PID: decide, P, I, D multiplies, accumulate, duty, mix, load.
//   One 17x32 multiplier is shared by the three PID terms and the wheel mix,
//   and one loop beat is worked on at a time.
// A new loop beat is taken only once the last one is in the output register.
// A finished drive beat sits in an output register; the next loop beat is
//   accepted and worked on while it waits, and holds before its own result
//   until drive_stall drops.
// Reset: registers take their default values, mode is steer, speeds,
//   integrator and previous error are zero, no drive beat is pending.
module omniwheel_pid_approach_drive_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [opd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [opd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           loop_valid,
    output logic                           loop_stall,
    input  opd_pkg::loop_item_t            loop_item,
    output logic                           drive_valid,
    input  logic                           drive_stall,
    output opd_pkg::drive_item_t           drive_item
);
    import opd_pkg::*;

    opd_cmd_t    cmd;
    opd_status_t status;

    opd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .loop_valid (loop_valid),
        .loop_stall (loop_stall),
        .status     (status),
        .cmd        (cmd)
    );

    opd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .loop_item   (loop_item),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_item  (drive_item),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

>>> hdl/opd_checker.sv
module opd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           loop_valid,
    input logic                           loop_stall,
    input logic                           drive_valid,
    input logic                           drive_stall,
    input opd_pkg::drive_item_t           drive_item
);
    import opd_pkg::*;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 15'd32440;

    a_drive_hold: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid && drive_stall |=> drive_valid && $stable(drive_item))
        else $error("drive beat dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        loop_valid && !loop_stall |=> loop_stall)
        else $error("loop beat accepted while another is in flight");

    a_split_excl: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |->
            (drive_item.wheel_one_fwd == '0 || drive_item.wheel_one_rev == '0) &&
            (drive_item.wheel_two_fwd == '0 || drive_item.wheel_two_rev == '0) &&
            (drive_item.wheel_three_fwd == '0 || drive_item.wheel_three_rev == '0))
        else $error("wheel driven forward and reverse at once");

    a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |->
            drive_item.wheel_one_fwd <= DUTY_MAX && drive_item.wheel_one_rev <= DUTY_MAX &&
            drive_item.wheel_two_fwd <= DUTY_MAX && drive_item.wheel_two_rev <= DUTY_MAX &&
            drive_item.wheel_three_fwd <= DUTY_MAX &&
            drive_item.wheel_three_rev <= DUTY_MAX)
        else $error("wheel duty beyond limit");

endmodule

bind omniwheel_pid_approach_drive_top opd_checker u_opd_checker (.*);

>>> verif/omniwheel_pid_approach_drive_top_tb.sv
`timescale 1ns / 1ps

module omniwheel_pid_approach_drive_top_tb;
    import opd_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int SOAK_ITEMS  = 40;
    localparam int CYCLE_LIMIT = 4 * (SOAK_ITEMS * 10 + 1000 * 20) + 20000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int SET_HIGH   = 0;
    localparam int SET_ZERO   = 1;
    localparam int SET_RANDOM = 2;
    localparam int SET_WILD   = 3;
    localparam int SET_SOAK   = 4;

    localparam int     STEER_ONE   = 32768;
    localparam int     ROOT3_HALF  = 56756;
    localparam int     WHEEL_LIMIT = 32440;
    localparam longint DUTY_MIN    = -64'sd32768;
    localparam longint INTEG_MAX   = 64'sd2147483647;
    localparam longint INTEG_MIN   = -64'sd2147483648;

    class drive_scoreboard;
        int          gain_p;
        int          gain_i;
        int          gain_d;
        int          target;
        int          duty_cap;
        int          range_limit;
        bit          approach;
        int          speed_fwd;
        int          speed_lat;
        int          integ;
        int          last_err;
        drive_item_t expected_duties[$];
        int          beats;
        int          mismatches;

        function new();
            gain_p      = int'(GAIN_P_RST);
            gain_i      = int'(GAIN_I_RST);
            gain_d      = int'(GAIN_D_RST);
            target      = int'(TARGET_DISTANCE_RST);
            duty_cap    = int'(DUTY_CAP_RST);
            range_limit = int'(RANGE_LIMIT_RST);
            approach    = 1'b0;
            speed_fwd   = 0;
            speed_lat   = 0;
            integ       = 0;
            last_err    = 0;
            beats       = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P:          gain_p      = int'(data);
                REG_GAIN_I:          gain_i      = int'(data);
                REG_GAIN_D:          gain_d      = int'(data);
                REG_TARGET_DISTANCE: target      = int'(data[DIST_W-1:0]);
                REG_DUTY_CAP:        duty_cap    = int'(data[DUTY_W-1:0]);
                REG_RANGE_LIMIT:     range_limit = int'(data[DIST_W-1:0]);
                default: ;
            endcase
        endfunction

        function int clamp(longint w);
            if (w <= -WHEEL_LIMIT)
                return -WHEEL_LIMIT;
            if (w >= WHEEL_LIMIT)
                return WHEEL_LIMIT;
            return int'(w);
        endfunction

        function void split_duty(int w, output logic [DUTY_W-1:0] fwd,
                                 output logic [DUTY_W-1:0] rev);
            if (w < 0)
            begin
                fwd = '0;
                rev = DUTY_W'(-w);
            end
            else
            begin
                fwd = DUTY_W'(w);
                rev = '0;
            end
        endfunction

        function void note_loop(loop_item_t it);
            drive_item_t want;
            int          err;
            int          diff;
            longint      acc;
            longint      duty;
            longint      f;
            longint      l;
            if (!approach)
            begin
                if (it.host_valid)
                begin
                    speed_fwd = ((int'(it.host_byte) - int'(HOST_CENTRE)) * STEER_ONE)
                                / int'(HOST_CENTRE);
                    speed_lat = 0;
                    if (it.host_byte == HOST_CENTRE)
                        approach = 1'b1;
                end
            end
            else if (int'(it.distance) < range_limit)
            begin
                err = int'(it.distance) - target;
                acc = longint'(integ) + err;
                if (acc > INTEG_MAX)
                    acc = INTEG_MAX;
                if (acc < INTEG_MIN)
                    acc = INTEG_MIN;
                integ    = int'(acc);
                diff     = err - last_err;
                last_err = err;
                duty = (longint'(gain_p) * err + longint'(gain_i) * integ
                        + longint'(gain_d) * diff) >>> 5;
                if (duty > duty_cap)
                    duty = duty_cap;
                if (duty < DUTY_MIN)
                    duty = DUTY_MIN;
                speed_lat = int'(duty);
                speed_fwd = 0;
                if (int'(it.distance) == target)
                    approach = 1'b0;
            end
            f = speed_fwd;
            l = speed_lat;
            split_duty(clamp(f), want.wheel_one_fwd, want.wheel_one_rev);
            split_duty(clamp((-STEER_ONE * f + ROOT3_HALF * l) >>> 16),
                       want.wheel_two_fwd, want.wheel_two_rev);
            split_duty(clamp((-STEER_ONE * f - ROOT3_HALF * l) >>> 16),
                       want.wheel_three_fwd, want.wheel_three_rev);
            want.mode_now = approach;
            expected_duties.push_back(want);
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR %s", msg);
        endtask

        task cmp_field(string name, int got, int want);
            if (got != want)
                report($sformatf("beat %0d %s: got %0d, want %0d", beats, name, got, want));
        endtask

        task check_drive(drive_item_t got);
            drive_item_t want;
            beats++;
            if (expected_duties.size() == 0)
            begin
                report($sformatf("beat %0d: drive beat with no loop beat waiting", beats));
                return;
            end
            want = expected_duties.pop_front();
            cmp_field("wheel_one_fwd", got.wheel_one_fwd, want.wheel_one_fwd);
            cmp_field("wheel_one_rev", got.wheel_one_rev, want.wheel_one_rev);
            cmp_field("wheel_two_fwd", got.wheel_two_fwd, want.wheel_two_fwd);
            cmp_field("wheel_two_rev", got.wheel_two_rev, want.wheel_two_rev);
            cmp_field("wheel_three_fwd", got.wheel_three_fwd, want.wheel_three_fwd);
            cmp_field("wheel_three_rev", got.wheel_three_rev, want.wheel_three_rev);
            cmp_field("mode_now", got.mode_now, want.mode_now);
        endtask
    endclass

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  loop_valid  = 1'b0;
    logic                  loop_stall;
    loop_item_t            loop_item   = '0;
    logic                  drive_valid;
    logic                  drive_stall = 1'b0;
    drive_item_t           drive_item;

    drive_scoreboard sb;
    bit              quiet      = 1'b0;
    int              stall_left = 0;
    int              cycles     = 0;

    omniwheel_pid_approach_drive_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .loop_valid  (loop_valid),
        .loop_stall  (loop_stall),
        .loop_item   (loop_item),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_item  (drive_item)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("omniwheel_pid_approach_drive_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && loop_valid && !loop_stall)
            sb.note_loop(loop_item);
        if (rst_n && drive_valid && !drive_stall)
        begin
            sb.check_drive(drive_item);
            stall_left <= quiet ? 0 : $urandom_range(0, 4);
        end
    end

    always @(negedge clk)
    begin
        drive_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    task automatic send_loop(input logic valid, input logic [7:0] host,
                             input logic [DIST_W-1:0] range_val);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            loop_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        loop_valid <= 1'b1;
        loop_item  <= '{host_valid: valid, host_byte: host, distance: range_val};
        do
        begin
            @(posedge clk);
        end
        while (loop_stall);
        @(negedge clk);
    endtask

    // hold the sender until every drive beat is back
    task automatic wait_for_results();
        loop_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sb.expected_duties.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic load_setting(input int which);
        int tgt;
        case (which)
            SET_HIGH:
            begin
                cfg_write(REG_GAIN_P, '1);
                cfg_write(REG_GAIN_I, '1);
                cfg_write(REG_GAIN_D, '1);
                cfg_write(REG_TARGET_DISTANCE, '1);
                cfg_write(REG_DUTY_CAP, '1);
                cfg_write(REG_RANGE_LIMIT, '1);
                cfg_write(REG_SPARE_LO, CFG_DATA_W'($urandom));
                cfg_write(REG_SPARE_HI, CFG_DATA_W'($urandom));
            end
            SET_ZERO:
            begin
                cfg_write(REG_GAIN_P, '0);
                cfg_write(REG_GAIN_I, '0);
                cfg_write(REG_GAIN_D, '0);
                cfg_write(REG_TARGET_DISTANCE, '0);
                cfg_write(REG_DUTY_CAP, '0);
                cfg_write(REG_RANGE_LIMIT, '0);
            end
            SET_WILD:
            begin
                cfg_write(REG_GAIN_P, CFG_DATA_W'($urandom));
                cfg_write(REG_GAIN_I, CFG_DATA_W'($urandom));
                cfg_write(REG_GAIN_D, CFG_DATA_W'($urandom));
                cfg_write(REG_TARGET_DISTANCE, CFG_DATA_W'($urandom));
                cfg_write(REG_DUTY_CAP, CFG_DATA_W'($urandom));
                cfg_write(REG_RANGE_LIMIT, CFG_DATA_W'($urandom));
                cfg_write(REG_SPARE_LO, CFG_DATA_W'($urandom));
            end
            SET_SOAK:
            begin
                cfg_write(REG_GAIN_P, '0);
                cfg_write(REG_GAIN_I, CFG_DATA_W'(1));
                cfg_write(REG_GAIN_D, '0);
                cfg_write(REG_TARGET_DISTANCE, CFG_DATA_W'(16));
                cfg_write(REG_DUTY_CAP, '1);
                cfg_write(REG_RANGE_LIMIT, '1);
            end
            default:
            begin
                tgt = $urandom_range(0, 4000);
                cfg_write(REG_GAIN_P, CFG_DATA_W'($urandom_range(0, 4000)));
                cfg_write(REG_GAIN_I, CFG_DATA_W'($urandom_range(0, 1000)));
                cfg_write(REG_GAIN_D, CFG_DATA_W'($urandom_range(0, 4000)));
                cfg_write(REG_TARGET_DISTANCE, CFG_DATA_W'(tgt));
                cfg_write(REG_DUTY_CAP, CFG_DATA_W'($urandom_range(0, 32767)));
                cfg_write(REG_RANGE_LIMIT, CFG_DATA_W'($urandom_range(tgt + 1, 32767)));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n);
        logic       valid;
        logic [7:0] host;
        int         range_val;
        int         pick;
        for (int k = 0; k < n; k++)
        begin
            if (k % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (k % 97 == 96)
                wait_for_results();
            pick      = $urandom_range(0, 15);
            valid     = ($urandom_range(0, 7) != 0);
            host      = 8'($urandom);
            range_val = $urandom_range(0, 32767);
            if (!sb.approach)
            begin
                if (pick < 3)
                    host = HOST_CENTRE;
                else if (pick < 5)
                    host = pick[0] ? 8'hff : 8'h00;
            end
            else if (pick < 2)
                range_val = $urandom_range(sb.range_limit, 32767);
            else if (pick < 4)
                range_val = sb.target;
            else if (pick < 12)
                range_val = sb.target + int'($urandom_range(0, 800)) - 400;
            if (range_val < 0)
                range_val = 0;
            if (range_val > 32767)
                range_val = 32767;
            send_loop(valid, host, DIST_W'(range_val));
        end
    endtask

    initial
    begin
        int plan [6];
        plan = '{SET_HIGH, SET_ZERO, SET_RANDOM, SET_WILD, SET_RANDOM, SET_RANDOM};
        sb = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        send_loop(1'b1, 8'd0, '0);
        send_loop(1'b1, 8'd255, '1);
        send_loop(1'b1, 8'd128, '0);
        send_loop(1'b1, 8'd126, '0);
        send_loop(1'b1, 8'd63, '0);
        send_loop(1'b1, 8'd191, '0);
        send_loop(1'b0, 8'd0, '1);
        send_loop(1'b0, HOST_CENTRE, '0);
        send_loop(1'b1, HOST_CENTRE, '1);
        send_loop(1'b1, 8'd255, '1);
        send_loop(1'b1, 8'd0, RANGE_LIMIT_RST);
        send_loop(1'b0, 8'd0, RANGE_LIMIT_RST - 1);
        send_loop(1'b0, 8'd0, '0);
        send_loop(1'b1, 8'd0, 15'd561);
        send_loop(1'b0, 8'd0, TARGET_DISTANCE_RST);
        send_loop(1'b1, 8'd200, '0);
        send_loop(1'b1, HOST_CENTRE, '0);
        send_loop(1'b0, 8'd0, 15'd400);
        send_loop(1'b0, 8'd0, TARGET_DISTANCE_RST);

        run_random(200);
        foreach (plan[p])
        begin
            wait_for_results();
            load_setting(plan[p]);
            run_random(plan[p] == SET_ZERO ? 60 : 110);
        end

        // hold a large error on the integrator, then back off
        wait_for_results();
        load_setting(SET_SOAK);
        quiet = 1'b1;
        if (!sb.approach)
            send_loop(1'b1, HOST_CENTRE, '1);
        for (int k = 0; k < SOAK_ITEMS; k++)
            send_loop(k[0], k[7:0], 15'd32766);
        repeat (4) send_loop(1'b0, 8'd0, '0);
        send_loop(1'b0, 8'd0, 15'd16);

        wait_for_results();
        repeat (16) @(negedge clk);
        if (sb.mismatches == 0 && sb.expected_duties.size() == 0)
            $display("omniwheel_pid_approach_drive_top regression: pass");
        else
            $display("omniwheel_pid_approach_drive_top regression: fail");
        $finish;
    end

endmodule

>>> sim.f
hdl/opd_pkg.sv
hdl/opd_ctrl.sv
hdl/opd_datapath.sv
hdl/omniwheel_pid_approach_drive_top.sv
hdl/opd_checker.sv
verif/omniwheel_pid_approach_drive_top_tb.sv
